>>> hdl/sha256_pkg.sv
// sha256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } back_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

>>> hdl/sha256_message_hasher.sv
// sha256_message_hasher: streaming sha-256, byte in, eight digest words out
// depends on sha256_pkg, sha256_front, sha256_back
// throughput: one byte a cycle into the queue while in_stall is low; per block 64 bytes packed, 64 rounds, 1 fold
// the single round unit sets the rate: the back end takes no bytes while it compresses or emits
// digest words are emitted after the end beat once the last of one or two final blocks is folded in
// synchronous active-low reset restores the initial hash values and empties the queue
module sha256_message_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha256_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  assign in_item.msg_byte       = in_msg_byte;
  assign in_item.byte_present   = in_byte_present;
  assign in_item.end_of_message = in_end_of_message;

  sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .q_valid, .q_take, .q_item
  );

  sha256_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_item, .out_valid, .out_stall,
    .out_digest_word, .out_word_index, .out_last_word
  );
endmodule

>>> hdl/sha256_front.sv
// sha256_front: input stage and item queue between the port and the compression engine
// depends on sha256_pkg
module sha256_front #(
  parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha256_pkg::item_t   in_item,
  output logic                q_valid,
  input  logic                q_take,
  output sha256_pkg::item_t   q_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  // absent bytes without end are dropped here
  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall && (in_item.byte_present || in_item.end_of_message);
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    if (pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    if (push && !pop) cnt_nxt = cnt_r + (AW+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= in_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop on empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + (AW+1)'(1)) else $error("count slip");
endmodule

>>> hdl/sha256_back.sv
// sha256_back: block packing, padding, 64-round compression and digest output
// depends on sha256_pkg
module sha256_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  sha256_pkg::item_t  q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  sha256_pkg::back_state_t st_r, st_nxt;

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [63:0] len_r;
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic        fin_r;   // padding after compression
  logic        pad80_r; // 0x80 already placed
  logic        tail_r;  // length goes in this block
  logic        last_blk_r;

  logic [7:0]  byte_in;
  logic        put;
  logic        full;
  logic [31:0] t1, t2, wnew;

  // byte chosen by state: message byte, pad byte, zero or length byte
  always_comb begin
    byte_in = 8'h00;
    put     = 1'b0;
    case (st_r)
      sha256_pkg::ST_TAKE: begin
        put     = q_valid && q_item.byte_present;
        byte_in = q_item.msg_byte;
      end
      sha256_pkg::ST_PAD: begin
        put = 1'b1;
        if (!pad80_r) byte_in = 8'h80;
        else if (tail_r && pos_r >= 6'd56) byte_in = len_r[8*(7-pos_r[2:0]) +: 8];
      end
      default: ;
    endcase
  end

  assign full = put && (pos_r == 6'd63);

  always_comb begin
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    if (put) begin
      if (pos_r[1:0] == 2'd0) w_nxt[pos_r[5:2]] = {byte_in, 24'h0};
      else w_nxt[pos_r[5:2]][8*(3-pos_r[1:0]) +: 8] = byte_in;
    end
  end

  assign wnew = w_r[0] + sha256_pkg::sig0(w_r[1]) + w_r[9] + sha256_pkg::sig1(w_r[14]);
  assign t1 = v_r[7] + sha256_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha256_pkg::RoundK[rnd_r] + w_r[0];
  assign t2 = sha256_pkg::bsig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sha256_pkg::ST_TAKE:
        if (q_valid) begin
          if (full) st_nxt = sha256_pkg::ST_ROUND;
          else if (q_item.end_of_message) st_nxt = sha256_pkg::ST_PAD;
        end
      sha256_pkg::ST_PAD:
        if (full) st_nxt = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND:
        if (rnd_r == 6'd63) st_nxt = sha256_pkg::ST_FOLD;
      sha256_pkg::ST_FOLD:
        if (last_blk_r) st_nxt = sha256_pkg::ST_EMIT;
        else if (fin_r) st_nxt = sha256_pkg::ST_PAD;
        else st_nxt = sha256_pkg::ST_TAKE;
      sha256_pkg::ST_EMIT:
        if (!out_stall && oidx_r == 3'd7) st_nxt = sha256_pkg::ST_TAKE;
      default: st_nxt = sha256_pkg::ST_TAKE;
    endcase
  end

  always_comb begin
    q_take          = (st_r == sha256_pkg::ST_TAKE);
    out_valid       = (st_r == sha256_pkg::ST_EMIT);
    out_digest_word = h_r[oidx_r];
    out_word_index  = oidx_r;
    out_last_word   = (oidx_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= sha256_pkg::ST_TAKE;
      len_r      <= '0;
      pos_r      <= '0;
      rnd_r      <= '0;
      oidx_r     <= '0;
      fin_r      <= 1'b0;
      pad80_r    <= 1'b0;
      tail_r     <= 1'b0;
      last_blk_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitHash[32*(7-i) +: 32];
    end else begin
      st_r <= st_nxt;
      if (put) pos_r <= pos_r + 6'd1;
      case (st_r)
        sha256_pkg::ST_TAKE:
          if (q_valid) begin
            if (q_item.byte_present) len_r <= len_r + 64'd8;
            if (q_item.end_of_message) fin_r <= 1'b1;
          end
        sha256_pkg::ST_PAD: begin
          pad80_r <= 1'b1;
          if (full) tail_r <= 1'b1;
          else if (!pad80_r) tail_r <= (pos_r < 6'd56);
          if (pad80_r && tail_r && pos_r == 6'd63) last_blk_r <= 1'b1;
        end
        sha256_pkg::ST_ROUND: rnd_r <= rnd_r + 6'd1;
        sha256_pkg::ST_FOLD:
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        sha256_pkg::ST_EMIT:
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              len_r      <= '0;
              pos_r      <= '0;
              fin_r      <= 1'b0;
              pad80_r    <= 1'b0;
              tail_r     <= 1'b0;
              last_blk_r <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitHash[32*(7-i) +: 32];
            end
          end
        default: ;
      endcase
    end
    // schedule window shifts one word per round
    if (st_r == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
      if (full) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end

  a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sha256_pkg::ST_ROUND && rnd_r == 6'd63) |=> st_r == sha256_pkg::ST_FOLD)
    else $error("round count slip");
  a_round_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r == sha256_pkg::ST_ROUND) |-> rnd_r == 6'd0) else $error("round not at zero");
  a_emit_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fin_r && last_blk_r) else $error("digest before final block");
endmodule

>>> sim/sha256_message_hasher_tb.sv
// sha256_message_hasher_tb: self-checking bench for the streaming sha-256 hasher
// drives byte beats with random gaps, predicts digests in a scoreboard class
// depends on sha256_pkg (round constants, initial hash) and sha256_message_hasher
module sha256_message_hasher_tb;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  class digest_scoreboard;
    logic [63:0] msg_bits;
    logic [31:0] blk [16];
    int unsigned fill;
    logic [31:0] hash [8];
    digest_beat_t pending [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      msg_bits = '0;
      fill = 0;
      for (int i = 0; i < 8; i++) hash[i] = sha256_pkg::InitHash[255 - 32*i -: 32];
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int t = 0; t < 8; t++) v[t] = hash[t];
      for (int t = 0; t < 64; t++) begin
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[t] + w[t];
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) hash[t] += v[t];
    endfunction

    function void pack(logic [7:0] b);
      if (fill % 4 == 0) blk[fill/4] = '0;
      blk[fill/4][(3 - fill % 4)*8 +: 8] = b;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
    endfunction

    function void note_beat(logic [7:0] b, logic present, logic eom);
      logic [63:0] len;
      digest_beat_t d;
      if (present) begin
        pack(b);
        msg_bits += 64'd8;
      end
      if (!eom) return;
      len = msg_bits;
      pack(8'h80);
      while (fill != 56) pack(8'h00);
      for (int i = 7; i >= 0; i--) pack(len[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash[i];
        d.word_index = i[2:0];
        d.last_word = (i == 7);
        pending.insert(pending.size(), d);
      end
      restart();
    endfunction

    function void check_beat(logic [31:0] dw, logic [2:0] wi, logic lw);
      digest_beat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest beat %h idx %0d", dw, wi);
        return;
      end
      e = pending.pop_front();
      if (dw !== e.digest_word || wi !== e.word_index || lw !== e.last_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                   e.digest_word, e.word_index, e.last_word, dw, wi, lw);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_msg_byte = '0;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb = new();
  bit   gaps_on = 1'b1;
  bit   hold_req = 1'b0;
  int   sent = 0;
  longint cycles = 0;

  sha256_message_hasher DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("sha256_message_hasher_tb failed");
      $finish;
    end
  end

  // accepted beats feed the scoreboard and emitted digest words are checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_beat(in_msg_byte, in_byte_present, in_end_of_message);
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_digest_word, out_word_index, out_last_word);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(logic [7:0] b, logic present, logic eom);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_msg_byte <= b;
    in_byte_present <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_message(int len, bit absent_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, (i == len - 1) && !absent_end);
    end
    if (absent_end || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // empty message, idle beat, one-byte messages at the byte extremes, one ended by an absent beat
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b1);
    // lengths around the one/two final block boundary
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    hold_req = 1'b1;
    send_message(64, 1'b1);
    while (sent < 390) begin
      case ($urandom_range(0, 3))
        0: send_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
        1: send_message($urandom_range(50, 70), 1'($urandom_range(0, 1)));
        2: send_message($urandom_range(0, 140), 1'b0);
        default: send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      endcase
    end
    gaps_on = 1'b0;
    send_message(60, 1'b0);
    send_message(3, 1'b0);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("sha256_message_hasher_tb passed");
    else
      $display("sha256_message_hasher_tb failed");
    $finish;
  end
endmodule
